### rtl/core/ssp_pkg.sv
// Shared widths and small types for the shelf strip packer.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int STRIP_W   = 15;
    localparam int PIECE_W   = 12;
    localparam int FDIM_W    = 10;
    localparam int POSX_W    = 15;
    localparam int POSY_W    = 16;
    localparam int HEIGHT_W  = 16;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 64;

    localparam logic [STRIP_W-1:0] STRIP_RESET = 15'd64;

    // Output tdata field offsets, lowest first
    localparam int OUT_X_LSB  = PIECE_W;
    localparam int OUT_Y_LSB  = OUT_X_LSB + POSX_W;
    localparam int OUT_R_LSB  = OUT_Y_LSB + POSY_W;
    localparam int OUT_F_LSB  = OUT_R_LSB + 2;
    localparam int OUT_H_LSB  = OUT_F_LSB + 1;

    typedef struct packed {
        logic [1:0] rot;
        logic       flip;
    } t_orient;

endpackage

### rtl/core/shelf_strip_packer.sv
// Next-fit shelf strip packer: one candidate orientation per cycle while the output is not stalled.
// Results: the closing orientation of a piece passes the input register, then the result register.
// Throughput: one orientation a cycle unless stalled; the shelf state updates combinationally from its registers.
// Stalls: input register and result register, ready drops only when both hold
// and the receiver is not ready.
// Reset (i_rst_n low, synchronous): strip width 64, cursor, shelf and trackers clear.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

module shelf_strip_packer
    import ssp_pkg::*;
#(
    parameter int DIM_BITS = 10,
    parameter int POS_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: strip width
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [STRIP_W-1:0]    i_cfg_data,
    // candidate orientations
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // piece_id[11:0], orient_width[21:12], orient_height[31:22],
    // rotation[33:32], flip[34], zero pad[39:35]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // start_layout[0]
    input  logic                  s_axis_tuser,
    // last_orientation
    input  logic                  s_axis_tlast,
    // placements
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // placed_piece[11:0], pos_x[26:12], pos_y[42:27], chosen_rotation[44:43],
    // chosen_flip[45], layout_height[61:46], zero pad[63:62]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // overflow[0]
    output logic                  m_axis_tuser
);

    // Sum width for position plus dimension, compare width against the strip
    localparam int SW = ((POS_BITS > DIM_BITS) ? POS_BITS : DIM_BITS) + 1;
    localparam int CW = (SW > STRIP_W) ? SW : STRIP_W;
    localparam int PW = (POS_BITS > HEIGHT_W) ? POS_BITS : HEIGHT_W;

    typedef struct packed {
        logic                valid;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        t_orient             o;
    } t_cand;

    // Saturating add of a position and a dimension or position
    function automatic logic [POS_BITS-1:0] sat_add(input logic [SW-1:0] a,
                                                    input logic [SW-1:0] b);
        logic [SW-1:0] s;
        s = a + b;
        if (|s[SW-1:POS_BITS]) return {POS_BITS{1'b1}};
        return s[POS_BITS-1:0];
    endfunction

    function automatic logic better(input t_cand t, input t_cand c);
        return !t.valid || (c.h < t.h) || ((c.h == t.h) && (c.w > t.w));
    endfunction

    // ---------------------------------------------------------------
    // Configuration: always ready; the user, not the block, ensures it is written only while idle
    // ---------------------------------------------------------------
    logic [STRIP_W-1:0] r_strip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip <= STRIP_RESET;
        end else if (i_cfg_valid) begin
            r_strip <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                r_in_valid;
    logic                r_in_start;
    logic                r_in_last;
    logic [PIECE_W-1:0]  r_in_piece;
    logic [FDIM_W-1:0]   r_in_w;
    logic [FDIM_W-1:0]   r_in_h;
    t_orient             r_in_o;

    logic r_out_valid;
    logic out_free;
    logic advance;

    // The result register frees when empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_start  <= s_axis_tuser;
            r_in_last   <= s_axis_tlast;
            r_in_piece  <= s_axis_tdata[PIECE_W-1:0];
            r_in_w      <= s_axis_tdata[PIECE_W +: FDIM_W];
            r_in_h      <= s_axis_tdata[PIECE_W+FDIM_W +: FDIM_W];
            r_in_o.rot  <= s_axis_tdata[PIECE_W+2*FDIM_W +: 2];
            r_in_o.flip <= s_axis_tdata[PIECE_W+2*FDIM_W+2];
        end
    end

    // ---------------------------------------------------------------
    // Shelf state and orientation trackers
    // ---------------------------------------------------------------
    logic [POS_BITS-1:0] r_cursor, n_cursor;
    logic [POS_BITS-1:0] r_base,   n_base;
    logic [DIM_BITS-1:0] r_shelf_h, n_shelf_h;
    t_cand               r_here,   n_here;
    t_cand               r_fresh,  n_fresh;
    t_cand               r_narrow, n_narrow;

    // Values after an optional start of layout
    logic [POS_BITS-1:0] cur_cursor, cur_base;
    logic [DIM_BITS-1:0] cur_shelf_h;
    t_cand               cur_here, cur_fresh, cur_narrow;
    t_cand               cand;
    t_cand               upd_here, upd_fresh, upd_narrow;
    t_cand               pick;
    logic                fit_here, fit_fresh, close_shelf;
    logic [POS_BITS-1:0] px, py;
    logic [DIM_BITS-1:0] h_open;
    logic [SW-1:0]       total;
    logic                ovf;
    logic [POS_BITS-1:0] total_sat;

    always_comb begin
        // start_layout clears all shelf state and trackers, including a partly received run
        cur_cursor  = r_in_start ? '0 : r_cursor;
        cur_base    = r_in_start ? '0 : r_base;
        cur_shelf_h = r_in_start ? '0 : r_shelf_h;
        cur_here    = r_in_start ? '0 : r_here;
        cur_fresh   = r_in_start ? '0 : r_fresh;
        cur_narrow  = r_in_start ? '0 : r_narrow;

        cand.valid = 1'b1;
        cand.w     = DIM_BITS'(r_in_w);
        cand.h     = DIM_BITS'(r_in_h);
        cand.o     = r_in_o;

        fit_here  = (CW'(SW'(cur_cursor) + SW'(cand.w))) <= CW'(r_strip);
        fit_fresh = CW'(cand.w) <= CW'(r_strip);

        upd_here   = (fit_here && better(cur_here, cand)) ? cand : cur_here;
        upd_fresh  = (fit_fresh && better(cur_fresh, cand)) ? cand : cur_fresh;
        upd_narrow = (!cur_narrow.valid || (cand.w < cur_narrow.w)) ? cand : cur_narrow;

        // Close the shelf when nothing fits on a shelf that holds something
        close_shelf = !upd_here.valid && (cur_cursor != '0);
        px     = close_shelf ? '0 : cur_cursor;
        py     = close_shelf ? sat_add(SW'(cur_base), SW'(cur_shelf_h)) : cur_base;
        h_open = close_shelf ? '0 : cur_shelf_h;

        if (upd_here.valid) begin
            pick = upd_here;
        end else if (upd_fresh.valid) begin
            pick = upd_fresh;
        end else begin
            pick = upd_narrow;
        end

        if (r_in_last) begin
            n_cursor  = sat_add(SW'(px), SW'(pick.w));
            n_base    = py;
            n_shelf_h = (pick.h > h_open) ? pick.h : h_open;
            n_here    = '0;
            n_fresh   = '0;
            n_narrow  = '0;
        end else begin
            n_cursor  = cur_cursor;
            n_base    = cur_base;
            n_shelf_h = cur_shelf_h;
            n_here    = upd_here;
            n_fresh   = upd_fresh;
            n_narrow  = upd_narrow;
        end

        total     = SW'(py) + SW'(n_shelf_h);
        ovf       = |total[SW-1:POS_BITS];
        total_sat = ovf ? {POS_BITS{1'b1}} : total[POS_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_base    <= '0;
            r_shelf_h <= '0;
            r_here    <= '0;
            r_fresh   <= '0;
            r_narrow  <= '0;
        end else if (advance) begin
            r_cursor  <= n_cursor;
            r_base    <= n_base;
            r_shelf_h <= n_shelf_h;
            r_here    <= n_here;
            r_fresh   <= n_fresh;
            r_narrow  <= n_narrow;
        end
    end

    // ---------------------------------------------------------------
    // Result register: loads only on the closing orientation of a piece
    // ---------------------------------------------------------------
    logic [PW-1:0]       px_ext, py_ext, tot_ext;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                r_out_ovf;

    assign px_ext  = PW'(px);
    assign py_ext  = PW'(py);
    assign tot_ext = PW'(total_sat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= {2'b00, tot_ext[HEIGHT_W-1:0], pick.o.flip, pick.o.rot,
                           py_ext[POSY_W-1:0], px_ext[POSX_W-1:0], r_in_piece};
            r_out_ovf  <= ovf;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_ovf;

endmodule

### rtl/core/ssp_checker.sv
// Port-level checks for the shelf strip packer, bound to the top level.
// Depends on ssp_pkg.
`timescale 1ns / 1ps

module ssp_checker
    import ssp_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    localparam logic [HEIGHT_W-1:0] HMAX = HEIGHT_W'((64'd1 << POS_BITS) - 64'd1);

    logic [HEIGHT_W-1:0] out_h;
    logic [POSY_W-1:0]   out_y;

    assign out_h = m_axis_tdata[OUT_H_LSB +: HEIGHT_W];
    assign out_y = m_axis_tdata[OUT_Y_LSB +: POSY_W];

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // A held result stays put while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Input back-pressure only comes from a full, stalled output
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // Overflow means the layout height is saturated
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> out_h == HMAX)
        else $error("overflow without saturated height");

    // The layout top never lies below the shelf base
    a_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (POS_BITS > HEIGHT_W) || (out_h >= out_y))
        else $error("layout height below shelf base");

endmodule

bind shelf_strip_packer ssp_checker #(.POS_BITS(POS_BITS)) u_ssp_checker (.*);
